### rtl/ttrt_pkg.sv
// ----------------------------------------------------------------------------
// ttrt_pkg: shared types and codes
// Command and result structs, op and kind codes, register indexes.
// ----------------------------------------------------------------------------
package ttrt_pkg;

	localparam logic [2:0] OP_ALLOC = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_TICK  = 3'd2;
	localparam logic [2:0] OP_FREE  = 3'd3;
	localparam logic [2:0] OP_QUERY = 3'd4;
	localparam logic [2:0] OP_SEED  = 3'd5;

	localparam logic [1:0] K_ANSWER     = 2'd0;
	localparam logic [1:0] K_RETRANSMIT = 2'd1;
	localparam logic [1:0] K_FAILED     = 2'd2;

	localparam logic CFG_TIMEOUT = 1'b0;
	localparam logic CFG_RETRY   = 1'b1;

	localparam logic [15:0] TIMEOUT_RST = 16'd3000;
	localparam logic [7:0]  RETRY_RST   = 8'd3;
	localparam logic [7:0]  NEXT_ID_RST = 8'd1;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  invoke_id;
		logic [15:0] elapsed_ms;
		logic [15:0] payload_len;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  result_id;
		logic        id_free;
		logic        id_failed;
		logic        space_available;
		logic [4:0]  idle_count;
		logic [15:0] reloaded_timer_ms;
		logic        last;
	} res_t;

	// next id after the given one, never zero
	function automatic logic [7:0] step_id(input logic [7:0] id);
		logic [7:0] n;
		n = id + 8'd1;
		return (n == 8'd0) ? 8'd1 : n;
	endfunction

endpackage

### rtl/transaction_table_with_retry_timers.sv
// ----------------------------------------------------------------------------
// transaction_table_with_retry_timers
// Table of outstanding transactions with retry timers, walked one entry per
// cycle by a small sequencer.
// ----------------------------------------------------------------------------
//  channel   signals                       transfer
//  command   start, busy, cmd              start && !busy at clk rise
//  result    result_valid, result          one cycle per strobe, no stall
//  config    cfg_we, cfg_index, cfg_data   cfg_we at clk rise
//
// Every command ends with a status walk over all entries. Seed, query and
// ignored starts go straight to it; start and free first search for the
// id, and tick first walks every entry. Allocate walks for a free slot and,
// if one is found, probes the table once per id (at most ENTRIES probes).
// Tick events come at most one per cycle during the tick walk, answer last.
// Reset clears the table at once; results cannot be stalled.
module transaction_table_with_retry_timers #(
	parameter int ENTRIES = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  ttrt_pkg::cmd_t cmd,
	output logic           result_valid,
	output ttrt_pkg::res_t result,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [15:0]    cfg_data
);
	import ttrt_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	typedef enum logic [2:0] {
		S_IDLE, S_ZERO, S_PROBE, S_FIND, S_TICK, S_STAT
	} state_t;

	state_t state_q;
	logic [7:0]  ent_id_q  [ENTRIES];
	logic        ent_aw_q  [ENTRIES];
	logic [15:0] ent_tmr_q [ENTRIES];
	logic [7:0]  ent_rty_q [ENTRIES];
	logic [7:0]  next_id_q;
	logic [15:0] timeout_q;
	logic [7:0]  retry_q;
	cmd_t        cmd_q;
	logic [IW-1:0] idx_q, slot_q;
	logic [7:0]  ans_id_q;
	logic        space_q, found_q, fl_q;
	logic [CW-1:0] idle_q;
	logic        busy_q, rv_q;
	res_t        res_q;

	logic [7:0]  cur_id, cur_rty;
	logic        cur_aw;
	logic [15:0] cur_tmr, tmr_dec;
	logic        at_end, hit, sp_n, fnd_n, fl_n, rv_n;
	logic [CW-1:0] idle_n;
	res_t        ev_res, ans_res;

	always_comb begin
		cur_id  = ent_id_q[idx_q];
		cur_aw  = ent_aw_q[idx_q];
		cur_tmr = ent_tmr_q[idx_q];
		cur_rty = ent_rty_q[idx_q];
		tmr_dec = (cur_tmr > cmd_q.elapsed_ms) ? cur_tmr - cmd_q.elapsed_ms : 16'd0;
		at_end  = (idx_q == LAST_IDX);
		hit     = (cur_id == cmd_q.invoke_id);
		sp_n    = space_q | (cur_id == 8'd0);
		idle_n  = idle_q + CW'((cur_id == 8'd0) && !cur_aw);
		fnd_n   = found_q | hit;
		fl_n    = found_q ? fl_q : (hit && !cur_aw);

		ev_res = '0;
		ev_res.result_id = cur_id;
		if (cur_rty < retry_q) begin
			ev_res.kind              = K_RETRANSMIT;
			ev_res.reloaded_timer_ms = timeout_q;
		end else begin
			ev_res.kind = K_FAILED;
		end

		ans_res = '0;
		ans_res.kind            = K_ANSWER;
		ans_res.result_id       = ans_id_q;
		ans_res.id_free         = !fnd_n;
		ans_res.id_failed       = fl_n;
		ans_res.space_available = sp_n;
		ans_res.idle_count      = 5'(idle_n);
		ans_res.last            = 1'b1;

		// an unused slot that runs out of retries fails silently
		rv_n = 1'b0;
		if (state_q == S_TICK) begin
			rv_n = cur_aw && (tmr_dec == 16'd0) && ((cur_rty < retry_q) || (cur_id != 8'd0));
		end else if (state_q == S_STAT) begin
			rv_n = at_end;
		end
	end

	assign busy         = busy_q;
	assign result_valid = rv_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			busy_q    <= 1'b0;
			rv_q      <= 1'b0;
			next_id_q <= NEXT_ID_RST;
			timeout_q <= TIMEOUT_RST;
			retry_q   <= RETRY_RST;
			idx_q     <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				ent_id_q[i]  <= 8'd0;
				ent_aw_q[i]  <= 1'b0;
				ent_tmr_q[i] <= 16'd0;
				ent_rty_q[i] <= 8'd0;
			end
		end else begin
			rv_q <= rv_n;
			if (cfg_we) begin
				case (cfg_index)
					CFG_TIMEOUT: timeout_q <= cfg_data;
					CFG_RETRY:   retry_q   <= cfg_data[7:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						busy_q   <= 1'b1;
						cmd_q    <= cmd;
						idx_q    <= '0;
						ans_id_q <= 8'd0;
						space_q  <= 1'b0;
						found_q  <= 1'b0;
						fl_q     <= 1'b0;
						idle_q   <= '0;
						case (cmd.op)
							OP_ALLOC: state_q <= S_ZERO;
							OP_START: begin
								if (cmd.invoke_id == 8'd0 || cmd.payload_len == 16'd0) begin
									state_q <= S_STAT;
								end else begin
									state_q <= S_FIND;
								end
							end
							OP_TICK:  state_q <= S_TICK;
							OP_FREE:  state_q <= S_FIND;
							OP_SEED: begin
								next_id_q <= (cmd.invoke_id == 8'd0) ? 8'd1 : cmd.invoke_id;
								state_q   <= S_STAT;
							end
							default:  state_q <= S_STAT;
						endcase
					end
				end
				S_ZERO: begin
					if (cur_id == 8'd0) begin
						slot_q  <= idx_q;
						idx_q   <= '0;
						state_q <= S_PROBE;
					end else if (at_end) begin
						idx_q   <= '0;
						state_q <= S_STAT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_PROBE: begin
					if (cur_id == next_id_q) begin
						// id in use: try the next one from the top
						next_id_q <= step_id(next_id_q);
						idx_q     <= '0;
					end else if (at_end) begin
						ent_id_q[slot_q]  <= next_id_q;
						ent_aw_q[slot_q]  <= 1'b0;
						ent_tmr_q[slot_q] <= timeout_q;
						ans_id_q  <= next_id_q;
						next_id_q <= step_id(next_id_q);
						idx_q     <= '0;
						state_q   <= S_STAT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_FIND: begin
					if (hit) begin
						if (cmd_q.op == OP_START) begin
							ent_aw_q[idx_q]  <= 1'b1;
							ent_rty_q[idx_q] <= 8'd0;
							ent_tmr_q[idx_q] <= timeout_q;
						end else begin
							ent_aw_q[idx_q] <= 1'b0;
							ent_id_q[idx_q] <= 8'd0;
						end
						idx_q   <= '0;
						state_q <= S_STAT;
					end else if (at_end) begin
						idx_q   <= '0;
						state_q <= S_STAT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_TICK: begin
					if (cur_aw) begin
						if (tmr_dec != 16'd0) begin
							ent_tmr_q[idx_q] <= tmr_dec;
						end else begin
							res_q <= ev_res;
							if (cur_rty < retry_q) begin
								ent_tmr_q[idx_q] <= timeout_q;
								ent_rty_q[idx_q] <= cur_rty + 8'd1;
							end else begin
								ent_tmr_q[idx_q] <= 16'd0;
								ent_aw_q[idx_q]  <= 1'b0;
							end
						end
					end
					idx_q <= at_end ? '0 : idx_q + 1'b1;
					if (at_end) begin
						state_q <= S_STAT;
					end
				end
				S_STAT: begin
					space_q <= sp_n;
					idle_q  <= idle_n;
					found_q <= fnd_n;
					fl_q    <= fl_n;
					if (at_end) begin
						res_q   <= ans_res;
						busy_q  <= 1'b0;
						idx_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/ttrt_checker.sv
// ----------------------------------------------------------------------------
// ttrt_checker: port-level checks
// Command/result sequencing seen at the top level's ports.
// ----------------------------------------------------------------------------
module ttrt_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           result_valid,
	input ttrt_pkg::res_t result
);
	import ttrt_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after command transfer");

	a_event_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> busy)
		else $error("event outside a command");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> !busy)
		else $error("answer while still busy");

	a_kind_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((result.kind == K_ANSWER) == result.last))
		else $error("last flag does not match answer kind");

	a_fell_answer: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_valid && result.last)
		else $error("command ended without answer");

endmodule

bind transaction_table_with_retry_timers ttrt_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.result_valid(result_valid),
	.result(result)
);
